// ===== hdl/dfo_pkg.sv =====
// shared types and constants for the distance fade opacity block
`timescale 1ns / 1ps
`default_nettype none

package dfo_pkg;

   // fixed field widths
   localparam int AXIS_W     = 16;
   localparam int AXIS_FRAC  = 14;
   localparam int START_W    = 23;
   localparam int FADE_W     = 24;
   localparam int MASK_W     = 64;
   localparam int AXIS_PKD_W = 3 * AXIS_W;

   // radial path: magnitude clamp at 2^24, squares and their sum
   localparam int RMAG_W  = 25;
   localparam int SQR_W   = 2 * RMAG_W;
   localparam int SUMSQ_W = SQR_W + 2;

   // distance limit squared fits 46 bits, so the root has 23 bits
   localparam int SQ_BITS = 23;
   localparam int SQ_IN_W = 2 * SQ_BITS;
   localparam int FSQ_W   = 2 * START_W;

   // divider operand width: end minus start in axis units
   localparam int DEN_W = START_W + AXIS_FRAC + 1;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam csr_idx_type CSR_COVER_X   = 3'd0;
   localparam csr_idx_type CSR_COVER_Y   = 3'd1;
   localparam csr_idx_type CSR_COVER_Z   = 3'd2;
   localparam csr_idx_type CSR_AXIS      = 3'd3;
   localparam csr_idx_type CSR_START     = 3'd4;
   localparam csr_idx_type CSR_END       = 3'd5;
   localparam csr_idx_type CSR_ROOM_MASK = 3'd6;

   // decision flags that ride along with each beat
   typedef struct packed {
      logic hidden;
      logic opaque;
      logic zero;
      logic full;
   } flags_type;

endpackage

`default_nettype wire

// ===== hdl/distance_fade_opacity.sv =====
// top level: opacity of one fade cover from viewer position and visible rooms
//
//   channel  direction  handshake          payload
//   req      in         req_valid/ready    view x,y,z, rooms_visible
//   rsp      out        rsp_valid/ready    opacity, drawn, opaque_from_view
//   csr      in         csr_write_en       csr_index, csr_wdata
//
// one beat per cycle in and out while rsp_ready does not hold the pipeline
// the pipeline holds a 23-stage square root and one divider stage per alpha bit
// the whole pipeline holds while a result waits and rsp_ready is low
// synchronous reset clears valid bits and sets the configuration registers to their defaults
`timescale 1ns / 1ps
`default_nettype none

module distance_fade_opacity
   import dfo_pkg::*;
#(
   parameter int COORD_BITS = 24,
   parameter int ALPHA_BITS = 8
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic signed [COORD_BITS-1:0] req_view_x,
   input  wire logic signed [COORD_BITS-1:0] req_view_y,
   input  wire logic signed [COORD_BITS-1:0] req_view_z,
   input  wire logic [MASK_W-1:0]            req_rooms_visible,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [ALPHA_BITS-1:0]             rsp_opacity,
   output logic                              rsp_drawn,
   output logic                              rsp_opaque_from_view,
   input  wire logic                         csr_write_en,
   input  wire csr_idx_type                  csr_index,
   input  wire logic [CSR_DATA_W-1:0]        csr_wdata
);

   localparam int OFF_W  = COORD_BITS + 1;
   localparam int PROD_W = COORD_BITS + AXIS_W + 1;
   localparam int DOT_W  = COORD_BITS + AXIS_W + 3;
   localparam int CMP_W  = (DOT_W > DEN_W) ? DOT_W : DEN_W;
   localparam int MAGX_W = (OFF_W > RMAG_W) ? OFF_W : RMAG_W;
   localparam logic [ALPHA_BITS-1:0] AMAX = '1;
   localparam logic [RMAG_W-1:0] RCLAMP = RMAG_W'(1) << (RMAG_W - 1);

   // configuration registers
   logic signed [COORD_BITS-1:0] cover_ff [3];
   logic [AXIS_PKD_W-1:0]        axis_ff;
   logic [START_W-1:0]           start_ff;
   logic [FADE_W-1:0]            end_ff;
   logic [MASK_W-1:0]            room_mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cover_ff[0]  <= '0;
         cover_ff[1]  <= '0;
         cover_ff[2]  <= '0;
         axis_ff      <= '0;
         start_ff     <= '0;
         end_ff       <= '1;
         room_mask_ff <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_COVER_X:   cover_ff[0]  <= csr_wdata[COORD_BITS-1:0];
            CSR_COVER_Y:   cover_ff[1]  <= csr_wdata[COORD_BITS-1:0];
            CSR_COVER_Z:   cover_ff[2]  <= csr_wdata[COORD_BITS-1:0];
            CSR_AXIS:      axis_ff      <= csr_wdata[AXIS_PKD_W-1:0];
            CSR_START:     start_ff     <= csr_wdata[START_W-1:0];
            CSR_END:       end_ff       <= csr_wdata[FADE_W-1:0];
            CSR_ROOM_MASK: room_mask_ff <= csr_wdata[MASK_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // global advance: the pipeline moves when the output slot frees up
   logic advance;
   logic rsp_valid_ff;
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   logic signed [AXIS_W-1:0] axis_s [3];
   logic [START_W-1:0] end_mag;
   logic axis_mode;
   logic fade_en;
   assign axis_s[0] = axis_ff[AXIS_W-1:0];
   assign axis_s[1] = axis_ff[2*AXIS_W-1:AXIS_W];
   assign axis_s[2] = axis_ff[3*AXIS_W-1:2*AXIS_W];
   assign axis_mode = |axis_ff;
   assign fade_en   = !end_ff[FADE_W-1];
   assign end_mag   = end_ff[START_W-1:0];

   // stage 1: offsets and room check
   logic signed [COORD_BITS-1:0] view_s [3];
   logic                    p1_valid_ff;
   logic                    p1_hidden_ff;
   logic signed [OFF_W-1:0] p1_off_ff [3];
   logic signed [OFF_W-1:0] p1_off_in [3];
   assign view_s[0] = req_view_x;
   assign view_s[1] = req_view_y;
   assign view_s[2] = req_view_z;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         p1_off_in[i] = OFF_W'(cover_ff[i]) - OFF_W'(view_s[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (advance) begin
         p1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p1_hidden_ff <= (req_rooms_visible & room_mask_ff) != room_mask_ff;
         for (int i = 0; i < 3; i++) begin
            p1_off_ff[i] <= p1_off_in[i];
         end
      end
   end

   // stage 2: axis products and clamped squares
   logic                     p2_valid_ff;
   logic                     p2_hidden_ff;
   logic signed [PROD_W-1:0] p2_prod_ff [3];
   logic signed [PROD_W-1:0] p2_prod_in [3];
   logic [SQR_W-1:0]         p2_sqr_ff [3];
   logic [SQR_W-1:0]         p2_sqr_in [3];
   logic [FSQ_W-1:0]         p2_ssq_ff;
   logic [FSQ_W-1:0]         p2_esq_ff;

   always_comb begin
      logic [OFF_W-1:0]  off_abs;
      logic [MAGX_W-1:0] mag_ext;
      logic [RMAG_W-1:0] mag;
      for (int i = 0; i < 3; i++) begin
         p2_prod_in[i] = p1_off_ff[i] * axis_s[i];
         off_abs = p1_off_ff[i][OFF_W-1] ? OFF_W'(-p1_off_ff[i]) : OFF_W'(p1_off_ff[i]);
         mag_ext = MAGX_W'(off_abs);
         mag     = (mag_ext > MAGX_W'(RCLAMP)) ? RCLAMP : mag_ext[RMAG_W-1:0];
         p2_sqr_in[i] = SQR_W'(mag * mag);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else if (advance) begin
         p2_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p2_hidden_ff <= p1_hidden_ff;
         p2_ssq_ff    <= FSQ_W'(start_ff * start_ff);
         p2_esq_ff    <= FSQ_W'(end_mag * end_mag);
         for (int i = 0; i < 3; i++) begin
            p2_prod_ff[i] <= p2_prod_in[i];
            p2_sqr_ff[i]  <= p2_sqr_in[i];
         end
      end
   end

   // stage 3: dot product and squared length sums
   logic                    p3_valid_ff;
   logic                    p3_hidden_ff;
   logic signed [DOT_W-1:0] p3_dot_ff;
   logic [SUMSQ_W-1:0]      p3_sq_ff;
   logic [FSQ_W-1:0]        p3_ssq_ff;
   logic [FSQ_W-1:0]        p3_esq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_valid_ff <= 1'b0;
      end else if (advance) begin
         p3_valid_ff <= p2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p3_hidden_ff <= p2_hidden_ff;
         p3_dot_ff    <= DOT_W'(p2_prod_ff[0]) + DOT_W'(p2_prod_ff[1])
                         + DOT_W'(p2_prod_ff[2]);
         p3_sq_ff     <= SUMSQ_W'(p2_sqr_ff[0]) + SUMSQ_W'(p2_sqr_ff[1])
                         + SUMSQ_W'(p2_sqr_ff[2]);
         p3_ssq_ff    <= p2_ssq_ff;
         p3_esq_ff    <= p2_esq_ff;
      end
   end

   // stage 4: band decisions and divider operands
   logic             p4_valid_ff;
   flags_type        p4_flags_ff;
   flags_type        p4_flags_in;
   logic             p4_radial_ff;
   logic [DEN_W-1:0] p4_num_ff;
   logic [DEN_W-1:0] p4_num_in;
   logic [DEN_W-1:0] p4_den_ff;
   logic [DEN_W-1:0] p4_den_in;
   logic [SQ_IN_W-1:0] p4_v_ff;

   always_comb begin
      logic [DOT_W-1:0] dabs;
      logic [CMP_W-1:0] dabs_x;
      logic [CMP_W-1:0] s14_x;
      logic [CMP_W-1:0] e14_x;
      logic zero_d;
      logic ge_d;
      dabs   = p3_dot_ff[DOT_W-1] ? DOT_W'(-p3_dot_ff) : DOT_W'(p3_dot_ff);
      dabs_x = CMP_W'(dabs);
      s14_x  = CMP_W'({start_ff, {AXIS_FRAC{1'b0}}});
      e14_x  = CMP_W'({end_mag, {AXIS_FRAC{1'b0}}});
      if (axis_mode) begin
         zero_d    = dabs_x <= s14_x;
         ge_d      = dabs_x >= e14_x;
         p4_den_in = DEN_W'(e14_x - s14_x);
      end else begin
         zero_d    = p3_sq_ff <= SUMSQ_W'(p3_ssq_ff);
         ge_d      = p3_sq_ff >= SUMSQ_W'(p3_esq_ff);
         p4_den_in = DEN_W'(end_mag - start_ff);
      end
      p4_num_in          = DEN_W'(dabs_x - s14_x);
      p4_flags_in.hidden = p3_hidden_ff;
      p4_flags_in.opaque = fade_en && ge_d;
      p4_flags_in.zero   = !fade_en || zero_d;
      p4_flags_in.full   = fade_en && !zero_d && ge_d;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p4_valid_ff <= 1'b0;
      end else if (advance) begin
         p4_valid_ff <= p3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p4_flags_ff  <= p4_flags_in;
         p4_radial_ff <= !axis_mode;
         p4_num_ff    <= p4_num_in;
         p4_den_ff    <= p4_den_in;
         p4_v_ff      <= p3_sq_ff[SQ_IN_W-1:0];
      end
   end

   // square root: one root bit per stage
   logic               sq_valid_ff  [SQ_BITS];
   flags_type          sq_flags_ff  [SQ_BITS];
   logic               sq_radial_ff [SQ_BITS];
   logic [DEN_W-1:0]   sq_num_ff    [SQ_BITS];
   logic [DEN_W-1:0]   sq_den_ff    [SQ_BITS];
   logic [SQ_IN_W-1:0] sq_v_ff      [SQ_BITS];
   logic [SQ_BITS+1:0] sq_rem_ff    [SQ_BITS];
   logic [SQ_BITS-1:0] sq_root_ff   [SQ_BITS];

   logic               sq_valid_in  [SQ_BITS];
   flags_type          sq_flags_in  [SQ_BITS];
   logic               sq_radial_in [SQ_BITS];
   logic [DEN_W-1:0]   sq_num_in    [SQ_BITS];
   logic [DEN_W-1:0]   sq_den_in    [SQ_BITS];
   logic [SQ_IN_W-1:0] sq_v_in      [SQ_BITS];
   logic [SQ_BITS+1:0] sq_rem_in    [SQ_BITS];
   logic [SQ_BITS-1:0] sq_root_in   [SQ_BITS];

   always_comb begin
      logic [SQ_BITS+1:0] rem_p;
      logic [SQ_BITS-1:0] root_p;
      logic [SQ_BITS+1:0] rem_sh;
      logic [SQ_BITS+1:0] trial;
      for (int k = 0; k < SQ_BITS; k++) begin
         if (k == 0) begin
            sq_valid_in[k]  = p4_valid_ff;
            sq_flags_in[k]  = p4_flags_ff;
            sq_radial_in[k] = p4_radial_ff;
            sq_num_in[k]    = p4_num_ff;
            sq_den_in[k]    = p4_den_ff;
            sq_v_in[k]      = p4_v_ff;
            rem_p           = '0;
            root_p          = '0;
         end else begin
            sq_valid_in[k]  = sq_valid_ff[k-1];
            sq_flags_in[k]  = sq_flags_ff[k-1];
            sq_radial_in[k] = sq_radial_ff[k-1];
            sq_num_in[k]    = sq_num_ff[k-1];
            sq_den_in[k]    = sq_den_ff[k-1];
            sq_v_in[k]      = sq_v_ff[k-1];
            rem_p           = sq_rem_ff[k-1];
            root_p          = sq_root_ff[k-1];
         end
         rem_sh = {rem_p[SQ_BITS-1:0], sq_v_in[k][2*(SQ_BITS-1-k) +: 2]};
         trial  = {root_p, 2'b01};
         if (rem_sh >= trial) begin
            sq_rem_in[k]  = rem_sh - trial;
            sq_root_in[k] = {root_p[SQ_BITS-2:0], 1'b1};
         end else begin
            sq_rem_in[k]  = rem_sh;
            sq_root_in[k] = {root_p[SQ_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SQ_BITS; k++) begin
            sq_valid_ff[k] <= 1'b0;
         end
      end else if (advance) begin
         for (int k = 0; k < SQ_BITS; k++) begin
            sq_valid_ff[k] <= sq_valid_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < SQ_BITS; k++) begin
            sq_flags_ff[k]  <= sq_flags_in[k];
            sq_radial_ff[k] <= sq_radial_in[k];
            sq_num_ff[k]    <= sq_num_in[k];
            sq_den_ff[k]    <= sq_den_in[k];
            sq_v_ff[k]      <= sq_v_in[k];
            sq_rem_ff[k]    <= sq_rem_in[k];
            sq_root_ff[k]   <= sq_root_in[k];
         end
      end
   end

   // pick the numerator: root minus start in radial mode
   logic             pm_valid_ff;
   flags_type        pm_flags_ff;
   logic [DEN_W-1:0] pm_num_ff;
   logic [DEN_W-1:0] pm_den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pm_valid_ff <= 1'b0;
      end else if (advance) begin
         pm_valid_ff <= sq_valid_ff[SQ_BITS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pm_flags_ff <= sq_flags_ff[SQ_BITS-1];
         pm_den_ff   <= sq_den_ff[SQ_BITS-1];
         pm_num_ff   <= sq_radial_ff[SQ_BITS-1]
                        ? DEN_W'(sq_root_ff[SQ_BITS-1] - start_ff)
                        : sq_num_ff[SQ_BITS-1];
      end
   end

   // divider
   logic                  dv_valid;
   flags_type             dv_flags;
   logic [ALPHA_BITS-1:0] dv_quot;

   dfo_div_pipe #(
      .ALPHA_BITS (ALPHA_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (pm_valid_ff),
      .in_flags  (pm_flags_ff),
      .in_num    (pm_num_ff),
      .in_den    (pm_den_ff),
      .out_valid (dv_valid),
      .out_flags (dv_flags),
      .out_quot  (dv_quot)
   );

   // output register
   logic [ALPHA_BITS-1:0] rsp_opacity_ff;
   logic [ALPHA_BITS-1:0] rsp_opacity_in;
   logic                  rsp_drawn_ff;
   logic                  rsp_drawn_in;
   logic                  rsp_opaque_ff;

   always_comb begin
      if (dv_flags.hidden || dv_flags.full) begin
         rsp_opacity_in = AMAX;
         rsp_drawn_in   = 1'b1;
      end else if (dv_flags.zero) begin
         rsp_opacity_in = '0;
         rsp_drawn_in   = 1'b0;
      end else begin
         rsp_opacity_in = dv_quot;
         rsp_drawn_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_opacity_ff <= rsp_opacity_in;
         rsp_drawn_ff   <= rsp_drawn_in;
         rsp_opaque_ff  <= dv_flags.opaque;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_opacity          = rsp_opacity_ff;
   assign rsp_drawn            = rsp_drawn_ff;
   assign rsp_opaque_from_view = rsp_opaque_ff;

   // checks
   a_undrawn_clear : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_drawn |-> rsp_opacity == '0)
      else $error("undrawn beat with nonzero opacity");

   // start at or past end can give an opaque but clear beat
   a_opaque_full : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_opaque_from_view && rsp_drawn |-> rsp_opacity == AMAX)
      else $error("drawn opaque beat without full opacity");

   a_band_flags : assert property (@(posedge clock) disable iff (reset)
      p4_valid_ff |-> !(p4_flags_ff.zero && p4_flags_ff.full))
      else $error("beat marked both clear and full");

endmodule

`default_nettype wire

// ===== hdl/dfo_div_pipe.sv =====
// pipelined restoring divider: floor(amax * num / den) for num below den
`timescale 1ns / 1ps
`default_nettype none

module dfo_div_pipe
   import dfo_pkg::*;
#(
   parameter int ALPHA_BITS = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire logic                  in_valid,
   input  wire flags_type             in_flags,
   input  wire logic [DEN_W-1:0]      in_num,
   input  wire logic [DEN_W-1:0]      in_den,
   output logic                       out_valid,
   output flags_type                  out_flags,
   output logic [ALPHA_BITS-1:0]      out_quot
);

   localparam int N_W = DEN_W + ALPHA_BITS;

   // scaled numerator stage
   logic            n_valid_ff;
   flags_type       n_flags_ff;
   logic [N_W-1:0]  n_ff;
   logic [N_W-1:0]  n_in;
   logic [DEN_W-1:0] n_den_ff;

   // one quotient bit per stage
   logic                  dv_valid_ff [ALPHA_BITS];
   flags_type             dv_flags_ff [ALPHA_BITS];
   logic [N_W-1:0]        dv_n_ff     [ALPHA_BITS];
   logic [DEN_W-1:0]      dv_den_ff   [ALPHA_BITS];
   logic [DEN_W-1:0]      dv_rem_ff   [ALPHA_BITS];
   logic [ALPHA_BITS-1:0] dv_quot_ff  [ALPHA_BITS];

   logic                  dv_valid_in [ALPHA_BITS];
   flags_type             dv_flags_in [ALPHA_BITS];
   logic [N_W-1:0]        dv_n_in     [ALPHA_BITS];
   logic [DEN_W-1:0]      dv_den_in   [ALPHA_BITS];
   logic [DEN_W-1:0]      dv_rem_in   [ALPHA_BITS];
   logic [ALPHA_BITS-1:0] dv_quot_in  [ALPHA_BITS];

   // amax * num as shift and subtract
   assign n_in = (N_W'(in_num) << ALPHA_BITS) - N_W'(in_num);

   always_ff @(posedge clock) begin
      if (reset) begin
         n_valid_ff <= 1'b0;
      end else if (advance) begin
         n_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         n_flags_ff <= in_flags;
         n_ff       <= n_in;
         n_den_ff   <= in_den;
      end
   end

   // division steps
   always_comb begin
      logic [DEN_W-1:0]      rem_p;
      logic [ALPHA_BITS-1:0] quot_p;
      logic [DEN_W:0]        rem_sh;
      logic [DEN_W:0]        diff;
      for (int k = 0; k < ALPHA_BITS; k++) begin
         if (k == 0) begin
            dv_valid_in[k] = n_valid_ff;
            dv_flags_in[k] = n_flags_ff;
            dv_n_in[k]     = n_ff;
            dv_den_in[k]   = n_den_ff;
            rem_p          = n_ff[N_W-1:ALPHA_BITS];
            quot_p         = '0;
         end else begin
            dv_valid_in[k] = dv_valid_ff[k-1];
            dv_flags_in[k] = dv_flags_ff[k-1];
            dv_n_in[k]     = dv_n_ff[k-1];
            dv_den_in[k]   = dv_den_ff[k-1];
            rem_p          = dv_rem_ff[k-1];
            quot_p         = dv_quot_ff[k-1];
         end
         rem_sh = {rem_p, dv_n_in[k][ALPHA_BITS-1-k]};
         diff   = rem_sh - {1'b0, dv_den_in[k]};
         if (rem_sh >= {1'b0, dv_den_in[k]}) begin
            dv_rem_in[k]  = diff[DEN_W-1:0];
            dv_quot_in[k] = {quot_p[ALPHA_BITS-2:0], 1'b1};
         end else begin
            dv_rem_in[k]  = rem_sh[DEN_W-1:0];
            dv_quot_in[k] = {quot_p[ALPHA_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < ALPHA_BITS; k++) begin
            dv_valid_ff[k] <= 1'b0;
         end
      end else if (advance) begin
         for (int k = 0; k < ALPHA_BITS; k++) begin
            dv_valid_ff[k] <= dv_valid_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < ALPHA_BITS; k++) begin
            dv_flags_ff[k] <= dv_flags_in[k];
            dv_n_ff[k]     <= dv_n_in[k];
            dv_den_ff[k]   <= dv_den_in[k];
            dv_rem_ff[k]   <= dv_rem_in[k];
            dv_quot_ff[k]  <= dv_quot_in[k];
         end
      end
   end

   assign out_valid = dv_valid_ff[ALPHA_BITS-1];
   assign out_flags = dv_flags_ff[ALPHA_BITS-1];
   assign out_quot  = dv_quot_ff[ALPHA_BITS-1];

endmodule

`default_nettype wire
